// ===== rtl/core/dpts_pkg.sv =====
`timescale 1ns / 1ps

package dpts_pkg;

   // Task ids grow to the table depth (up to 256) and need nine bits inside
   localparam int ID_W   = 9;
   localparam int PRIO_W = 16;
   localparam int REM_W  = 15;

   localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = -16'sd32767;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [1:0] STAT_ADDED = 2'd0;
   localparam logic [1:0] STAT_RAN   = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic                     valid;
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
      logic [REM_W-1:0]         rem;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '0;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_SHIFT,
      CMD_INSERT
   } cell_cmd_type;

endpackage

// ===== rtl/core/dpts_cell.sv =====
`timescale 1ns / 1ps

module dpts_cell
   import dpts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    new_entry,
   input  entry_type    left_entry,
   input  logic         left_keep,
   input  entry_type    right_entry,
   output entry_type    entry,
   output logic         keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // stay in place when ahead of the new entry (equal priority stays ahead)
   assign keep = entry_ff.valid && (entry_ff.prio >= new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      case (cmd)
         CMD_SHIFT: begin
            entry_in = right_entry;
         end
         CMD_INSERT: begin
            if (!keep) begin
               entry_in = left_keep ? new_entry : left_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/dynamic_priority_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   action, task_priority, task_time
// rsp_      out        rsp_valid/rsp_stall   status, task_id, remaining_time,
//                                            priority_after, task_finished, active_count
//
// Each item is handled at the accept edge (head removal on a tick) and then at the
// edge in which the chain of cells inserts the entry and the result is registered.
// The cell chain takes one command per cycle, so items are handled one at a time.
// Synchronous active-high reset empties the table and clears the id counter.
// A stalled result holds the ST_FIN state; the input is taken again once it moves.

module dynamic_priority_task_scheduler_top
   import dpts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic signed [15:0]       req_task_priority,
   input  logic [14:0]              req_task_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [4:0]               rsp_task_id,
   output logic [14:0]              rsp_remaining_time,
   output logic signed [15:0]       rsp_priority_after,
   output logic                     rsp_task_finished,
   output logic [4:0]               rsp_active_count
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FIN  = 2'b10
   } state_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_FULL,
      OP_EMPTY,
      OP_RUN
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   entry_type pend_ff, pend_in;
   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic [CNT_W-1:0] active_ff, active_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [4:0]               rsp_task_id_ff, rsp_task_id_in;
   logic [REM_W-1:0]         rsp_rem_ff, rsp_rem_in;
   logic signed [PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic                     rsp_fin_ff, rsp_fin_in;
   logic [4:0]               rsp_active_ff, rsp_active_in;

   cell_cmd_type             cmd;
   entry_type                cell_entry [MAX_TASKS];
   logic [MAX_TASKS-1:0]     keep_vec;
   logic [MAX_TASKS-1:0]     valid_vec;

   logic                     req_accept;
   logic                     out_free;
   logic                     has_task;
   logic signed [PRIO_W-1:0] prio_clamp;
   entry_type                head;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign head       = cell_entry[0];
   assign has_task   = (op_ff == OP_ADD) || (op_ff == OP_RUN);
   assign prio_clamp = (req_task_priority < PRIO_FLOOR) ? PRIO_FLOOR : req_task_priority;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pend_in       = pend_ff;
      loaded_in     = loaded_ff;
      active_in     = active_ff;
      cmd           = CMD_HOLD;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_task_id_in = rsp_task_id_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_active_in = rsp_active_ff;

      if (req_accept) begin
         state_in = ST_FIN;
         if (req_action == ACT_ADD) begin
            if (loaded_ff >= CNT_W'(MAX_TASKS)) begin
               op_in = OP_FULL;
            end else begin
               op_in         = OP_ADD;
               loaded_in     = loaded_ff + 1'b1;
               pend_in.valid = 1'b1;
               pend_in.id    = ID_W'(loaded_in);
               pend_in.prio  = prio_clamp;
               pend_in.rem   = req_task_time;
            end
         end else if (active_ff == '0) begin
            op_in = OP_EMPTY;
         end else begin
            // pull the head out; the chain shifts up behind it
            op_in         = OP_RUN;
            cmd           = CMD_SHIFT;
            active_in     = active_ff - 1'b1;
            pend_in.valid = 1'b1;
            pend_in.id    = head.id;
            pend_in.prio  = (head.prio > PRIO_FLOOR) ? head.prio - 16'sd1 : head.prio;
            pend_in.rem   = head.rem - 1'b1;
         end
      end

      if (state_ff == ST_FIN && out_free) begin
         state_in = ST_IDLE;
         if (has_task && pend_ff.rem != '0) begin
            cmd       = CMD_INSERT;
            active_in = active_ff + 1'b1;
         end
         rsp_valid_in = 1'b1;
         case (op_ff)
            OP_ADD:   rsp_status_in = STAT_ADDED;
            OP_RUN:   rsp_status_in = STAT_RAN;
            OP_EMPTY: rsp_status_in = STAT_EMPTY;
            default:  rsp_status_in = STAT_FULL;
         endcase
         rsp_task_id_in = has_task ? 5'(pend_ff.id) : 5'd0;
         rsp_rem_in     = has_task ? pend_ff.rem : '0;
         rsp_prio_in    = has_task ? pend_ff.prio : '0;
         rsp_fin_in     = has_task && (pend_ff.rem == '0);
         rsp_active_in  = 5'(active_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pend_ff        <= pend_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_task_id_ff <= rsp_task_id_in;
      rsp_rem_ff     <= rsp_rem_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_active_ff  <= rsp_active_in;
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      if (i == 0) begin : g_first
         assign left_entry = ENTRY_EMPTY;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_keep  = keep_vec[i-1];
      end

      if (i == MAX_TASKS - 1) begin : g_last
         assign right_entry = ENTRY_EMPTY;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      dpts_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_entry   (pend_ff),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (keep_vec[i])
      );

      assign valid_vec[i] = cell_entry[i].valid;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_task_id        = rsp_task_id_ff;
   assign rsp_remaining_time = rsp_rem_ff;
   assign rsp_priority_after = rsp_prio_ff;
   assign rsp_task_finished  = rsp_fin_ff;
   assign rsp_active_count   = rsp_active_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(active_ff))
      else $error("active count differs from occupied cells");

   a_active_le_loaded: assert property (@(posedge clock) disable iff (reset)
      active_ff <= loaded_ff)
      else $error("more active tasks than tasks ever added");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_entry[1].valid |-> (cell_entry[0].valid && cell_entry[0].prio >= cell_entry[1].prio))
      else $error("head out of priority order");

   a_accept_to_fin: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_FIN))
      else $error("accepted transfer did not start processing");

endmodule
